// ----- rtl/http_request_header_parser_defines.svh -----
// Assertion macros for the HTTP request header parser.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication.
`define HRHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hrhp_pkg.sv -----
// Package for the HTTP request header parser: payload structs, verdict codes,
// literal tables and character helpers. No dependencies.
package hrhp_pkg;

  localparam int unsigned LINE_BYTES_DEF = 128;
  localparam int unsigned BODY_BYTES_DEF = 128;
  localparam logic [11:0] MAX_HDR_RST  = 12'd1024;
  localparam logic [11:0] MAX_BODY_RST = 12'd128;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [9:0]  http_status;
    logic        is_head;
    logic [7:0]  body_byte;
    logic        body_byte_valid;
    logic [11:0] body_length;
  } out_t;

  typedef enum logic [1:0] {PH_LINE, PH_HEAD, PH_BODY, PH_DONE} phase_e;
  typedef enum logic [1:0] {CT_IDLE, CT_SCAN, CT_EVAL} ctl_e;
  typedef enum logic [1:0] {HK_OTHER, HK_LEN, HK_TYPE, HK_TE} hdr_kind_e;
  typedef enum logic [3:0] {
    L_POST, L_HEAD, L_GET, L_SET, L_VER, L_CL, L_CT, L_TE, L_FORM
  } lit_e;

  typedef enum logic [0:0] {REG_MAX_HDR, REG_MAX_BODY} reg_idx_e;

  localparam logic [3:0] V_PROGRESS   = 4'd0;
  localparam logic [3:0] V_PAGE       = 4'd1;
  localparam logic [3:0] V_FORM       = 4'd2;
  localparam logic [3:0] V_BAD_EOL    = 4'd3;
  localparam logic [3:0] V_INVALID    = 4'd4;
  localparam logic [3:0] V_HDR_LARGE  = 4'd5;
  localparam logic [3:0] V_METHOD     = 4'd6;
  localparam logic [3:0] V_NOT_FOUND  = 4'd7;
  localparam logic [3:0] V_BAD_HDR    = 4'd8;
  localparam logic [3:0] V_DUP_LEN    = 4'd9;
  localparam logic [3:0] V_EMPTY_LEN  = 4'd10;
  localparam logic [3:0] V_TOO_LARGE  = 4'd11;
  localparam logic [3:0] V_DUP_TYPE   = 4'd12;
  localparam logic [3:0] V_XFER_ENC   = 4'd13;
  localparam logic [3:0] V_LEN_REQ    = 4'd14;
  localparam logic [3:0] V_MEDIA      = 4'd15;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam int unsigned LEN_POST = 4;
  localparam int unsigned LEN_GET  = 3;
  localparam int unsigned LEN_SET  = 9;
  localparam int unsigned LEN_VER  = 8;
  localparam int unsigned LEN_CL   = 14;
  localparam int unsigned LEN_CT   = 12;
  localparam int unsigned LEN_TE   = 17;
  localparam int unsigned LEN_FORM = 33;

  localparam logic [8*LEN_POST-1:0] S_POST = "POST";
  localparam logic [8*LEN_POST-1:0] S_HEAD = "HEAD";
  localparam logic [8*LEN_GET-1:0]  S_GET  = "GET";
  localparam logic [8*LEN_SET-1:0]  S_SET  = "/set-time";
  localparam logic [8*LEN_VER-1:0]  S_VER  = "HTTP/1.1";
  localparam logic [8*LEN_CL-1:0]   S_CL   = "content-length";
  localparam logic [8*LEN_CT-1:0]   S_CT   = "content-type";
  localparam logic [8*LEN_TE-1:0]   S_TE   = "transfer-encoding";
  localparam logic [8*LEN_FORM-1:0] S_FORM = "application/x-www-form-urlencoded";

  // Per-line scan state, rebuilt from the line store on every line end.
  typedef struct packed {
    logic [1:0] sp;
    logic       mpost;
    logic       mhead;
    logic       mget;
    logic       mlen4;
    logic       mlen3;
    logic       tst;
    logic       tgt_bad;
    logic       qseen;
    logic       st_m;
    logic [3:0] tl;
    logic       vm;
    logic [3:0] vk;
    logic       col;
    logic       col0;
    logic       ncl;
    logic       nct;
    logic       nte;
    hdr_kind_e  hk;
    logic       vst;
    logic       pend;
    logic       lerr;
    logic [11:0] val;
    logic       fm;
    logic [5:0] tk;
    logic       semi33;
    logic       ws33;
    logic       nwa;
  } scan_t;

  function automatic logic [7:0] lit_at(lit_e sel, logic [5:0] k);
    logic [7:0] c;
    int unsigned ki;
    c = 8'h00;
    ki = int'(k);
    case (sel)
      L_POST: if (ki < LEN_POST) c = S_POST[8*(LEN_POST-1-ki) +: 8];
      L_HEAD: if (ki < LEN_POST) c = S_HEAD[8*(LEN_POST-1-ki) +: 8];
      L_GET:  if (ki < LEN_GET)  c = S_GET[8*(LEN_GET-1-ki) +: 8];
      L_SET:  if (ki < LEN_SET)  c = S_SET[8*(LEN_SET-1-ki) +: 8];
      L_VER:  if (ki < LEN_VER)  c = S_VER[8*(LEN_VER-1-ki) +: 8];
      L_CL:   if (ki < LEN_CL)   c = S_CL[8*(LEN_CL-1-ki) +: 8];
      L_CT:   if (ki < LEN_CT)   c = S_CT[8*(LEN_CT-1-ki) +: 8];
      L_TE:   if (ki < LEN_TE)   c = S_TE[8*(LEN_TE-1-ki) +: 8];
      L_FORM: if (ki < LEN_FORM) c = S_FORM[8*(LEN_FORM-1-ki) +: 8];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR;
  endfunction

  function automatic logic [9:0] status_of(logic [3:0] v);
    logic [9:0] s;
    case (v)
      V_PROGRESS:          s = 10'd0;
      V_PAGE, V_FORM:      s = 10'd200;
      V_HDR_LARGE:         s = 10'd431;
      V_METHOD:            s = 10'd405;
      V_NOT_FOUND:         s = 10'd404;
      V_TOO_LARGE:         s = 10'd413;
      V_LEN_REQ:           s = 10'd411;
      V_MEDIA:             s = 10'd415;
      default:             s = 10'd400;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/http_request_header_parser.sv -----
// HTTP request header parser top level: line store memory, line-end scanner
// and output register. Depends on hrhp_pkg and the defines header.
`include "http_request_header_parser_defines.svh"
// Usage:
//  Input channel (in_valid_i/in_ready_o, in_data_i) carries one transaction per
//  connection byte, or a new-connection marker (action = 1).
//  Output channel (out_valid_o/out_ready_i, out_data_o) returns exactly one
//  transaction per input transaction, in order.
//  Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//  (0 = max header bytes, 1 = max body length); write only while idle.
//  For ordinary bytes, body bytes and markers the result sits in the output
//  register in the cycle after acceptance.
//  A line feed that closes a stored line replays the bytes before its CR
//  from the single-port line store, one byte per cycle, then evaluates the
//  line; the result is loaded once the output register is free, and no
//  byte is taken until the result has been loaded.
//  Reset: all parse state and both registers return to their defaults
//  (1024 header bytes, 128 body length); the line store is not cleared.
//  A stalled receiver holds the result; a new transaction is taken in the
//  same cycle the waiting result leaves.
module http_request_header_parser #(
  parameter int unsigned LINE_BYTES = hrhp_pkg::LINE_BYTES_DEF,
  parameter int unsigned BODY_BYTES = hrhp_pkg::BODY_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hrhp_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hrhp_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [11:0]     cfg_data_i
);
  import hrhp_pkg::*;

  localparam int unsigned LW = $clog2(LINE_BYTES);

  logic [7:0]    mem [LINE_BYTES];
  logic [7:0]    rdata_q;
  logic          mem_we, rd_en;
  logic [7:0]    mem_wd;

  ctl_e          ctl_q, ctl_d;
  phase_e        phase_q, phase_d;
  logic [LW-1:0] line_len_q, line_len_d;
  logic          last_cr_q, last_cr_d;
  logic [12:0]   hdr_cnt_q, hdr_cnt_d;
  logic          post_q, post_d, head_q, head_d;
  logic          len_seen_q, len_seen_d, type_seen_q, type_seen_d;
  logic          type_valid_q, type_valid_d;
  logic [11:0]   decl_q, decl_d, body_cnt_q, body_cnt_d;
  logic [11:0]   max_hdr_q, max_body_q;
  scan_t         scan_q, scan_d;
  logic [LW-1:0] scan_len_q, scan_len_d, idx_q, idx_d, pos_q, pos_d;
  logic          rv_q, rv_d;
  out_t          out_q, res;
  logic          out_valid_q, emit, lf_go, in_acc, out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Line store: one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[line_len_q] <= mem_wd;
    if (rd_en) rdata_q <= mem[idx_q];
  end

  // Control FSM: next state
  always_comb begin
    ctl_d = ctl_q;
    case (ctl_q)
      CT_IDLE: if (lf_go) ctl_d = CT_SCAN;
      CT_SCAN: if (idx_q == scan_len_q && !rv_q) ctl_d = CT_EVAL;
      CT_EVAL: if (out_free) ctl_d = CT_IDLE;
      default: ctl_d = CT_IDLE;
    endcase
  end

  // Control FSM: outputs
  always_comb begin
    in_ready_o = 1'b0;
    case (ctl_q)
      CT_IDLE: in_ready_o = out_free;
      default: in_ready_o = 1'b0;
    endcase
  end

  // Datapath
  always_comb begin
    logic [7:0]  b, c;
    logic        fin, ign;
    logic [3:0]  v;
    logic [7:0]  bbyte;
    logic        bval;
    logic [15:0] nv;
    logic [5:0]  pk;
    b = in_data_i.data_byte;
    c = rdata_q;
    fin = 1'b0;
    ign = 1'b0;
    v = V_PROGRESS;
    bbyte = 8'h00;
    bval = 1'b0;
    nv = '0;
    pk = 6'(pos_q);
    emit = 1'b0;
    lf_go = 1'b0;
    mem_we = 1'b0;
    mem_wd = b;
    rd_en = 1'b0;
    phase_d = phase_q;
    line_len_d = line_len_q;
    last_cr_d = last_cr_q;
    hdr_cnt_d = hdr_cnt_q;
    post_d = post_q;
    head_d = head_q;
    len_seen_d = len_seen_q;
    type_seen_d = type_seen_q;
    type_valid_d = type_valid_q;
    decl_d = decl_q;
    body_cnt_d = body_cnt_q;
    scan_d = scan_q;
    scan_len_d = scan_len_q;
    idx_d = idx_q;
    pos_d = pos_q;
    rv_d = 1'b0;

    if (in_acc) begin
      emit = 1'b1;
      if (in_data_i.action) begin
        ign = 1'b1;
        phase_d = PH_LINE;
        line_len_d = '0;
        last_cr_d = 1'b0;
        hdr_cnt_d = '0;
        post_d = 1'b0;
        head_d = 1'b0;
        len_seen_d = 1'b0;
        type_seen_d = 1'b0;
        type_valid_d = 1'b0;
        decl_d = '0;
        body_cnt_d = '0;
      end else if (phase_q == PH_DONE) begin
        ign = 1'b1;
      end else if (phase_q == PH_BODY) begin
        if (body_cnt_q >= decl_q || {1'b0, body_cnt_q} >= 13'(BODY_BYTES)) begin
          fin = 1'b1;
          v = V_TOO_LARGE;
        end else begin
          bbyte = b;
          bval = 1'b1;
          body_cnt_d = body_cnt_q + 12'd1;
          if (body_cnt_d == decl_q) begin
            fin = 1'b1;
            v = V_FORM;
          end
        end
      end else begin
        hdr_cnt_d = hdr_cnt_q + 13'd1;
        if (hdr_cnt_d > {1'b0, max_hdr_q}) begin
          fin = 1'b1;
          v = V_HDR_LARGE;
        end else if (b == CH_LF) begin
          if (line_len_q == '0 || !last_cr_q) begin
            fin = 1'b1;
            v = V_BAD_EOL;
          end else begin
            emit = 1'b0;
            lf_go = 1'b1;
            scan_len_d = line_len_q - LW'(1);
            idx_d = '0;
            scan_d = '0;
            scan_d.mpost = 1'b1;
            scan_d.mhead = 1'b1;
            scan_d.mget = 1'b1;
            scan_d.st_m = 1'b1;
            scan_d.vm = 1'b1;
            scan_d.ncl = 1'b1;
            scan_d.nct = 1'b1;
            scan_d.nte = 1'b1;
            scan_d.hk = HK_OTHER;
            scan_d.fm = 1'b1;
          end
        end else if (b < CH_SP && b != CH_CR && b != CH_TAB || b == CH_DEL ||
                     line_len_q == LW'(LINE_BYTES - 1)) begin
          fin = 1'b1;
          v = V_INVALID;
        end else begin
          mem_we = 1'b1;
          line_len_d = line_len_q + LW'(1);
          last_cr_d = (b == CH_CR);
        end
      end
    end

    // Replay of the stored line
    if (ctl_q == CT_SCAN && idx_q != scan_len_q) begin
      rd_en = 1'b1;
      idx_d = idx_q + LW'(1);
      rv_d = 1'b1;
      pos_d = idx_q;
    end

    if (rv_q) begin
      if (phase_q == PH_LINE) begin
        case (scan_q.sp)
          2'd0: begin
            if (c == CH_SP) begin
              scan_d.sp = 2'd1;
              scan_d.mlen4 = (pos_q == LW'(LEN_POST));
              scan_d.mlen3 = (pos_q == LW'(LEN_GET));
            end else begin
              scan_d.mpost = scan_q.mpost && pos_q < LW'(LEN_POST) && c == lit_at(L_POST, pk);
              scan_d.mhead = scan_q.mhead && pos_q < LW'(LEN_POST) && c == lit_at(L_HEAD, pk);
              scan_d.mget  = scan_q.mget && pos_q < LW'(LEN_GET) && c == lit_at(L_GET, pk);
            end
          end
          2'd1: begin
            if (c == CH_SP) begin
              scan_d.sp = 2'd2;
              if (!scan_q.tst) scan_d.tgt_bad = 1'b1;
            end else begin
              if (!scan_q.tst && c != CH_SLASH) scan_d.tgt_bad = 1'b1;
              scan_d.tst = 1'b1;
              if (!scan_q.qseen) begin
                if (c == CH_QUEST) begin
                  scan_d.qseen = 1'b1;
                end else begin
                  scan_d.st_m = scan_q.st_m && scan_q.tl < 4'(LEN_SET) &&
                                c == lit_at(L_SET, 6'(scan_q.tl));
                  if (scan_q.tl < 4'(LEN_SET + 1)) scan_d.tl = scan_q.tl + 4'd1;
                end
              end
            end
          end
          2'd2: begin
            if (c == CH_SP) begin
              scan_d.sp = 2'd3;
            end else begin
              scan_d.vm = scan_q.vm && scan_q.vk < 4'(LEN_VER) &&
                          ((scan_q.vk == 4'(LEN_VER - 1)) ? (c == CH_ONE || c == CH_ZERO)
                                                          : c == lit_at(L_VER, 6'(scan_q.vk)));
              if (scan_q.vk < 4'(LEN_VER + 1)) scan_d.vk = scan_q.vk + 4'd1;
            end
          end
          default: scan_d.sp = scan_q.sp;
        endcase
      end else begin
        if (!scan_q.col) begin
          if (c == CH_COLON) begin
            scan_d.col = 1'b1;
            scan_d.col0 = (pos_q == '0);
            if (scan_q.ncl && pos_q == LW'(LEN_CL)) scan_d.hk = HK_LEN;
            else if (scan_q.nct && pos_q == LW'(LEN_CT)) scan_d.hk = HK_TYPE;
            else if (scan_q.nte && pos_q == LW'(LEN_TE)) scan_d.hk = HK_TE;
            else scan_d.hk = HK_OTHER;
          end else begin
            scan_d.ncl = scan_q.ncl && pos_q < LW'(LEN_CL) && to_lower(c) == lit_at(L_CL, pk);
            scan_d.nct = scan_q.nct && pos_q < LW'(LEN_CT) && to_lower(c) == lit_at(L_CT, pk);
            scan_d.nte = scan_q.nte && pos_q < LW'(LEN_TE) && to_lower(c) == lit_at(L_TE, pk);
          end
        end else if (scan_q.vst || !is_ws(c)) begin
          scan_d.vst = 1'b1;
          // decimal length
          if (is_ws(c)) begin
            scan_d.pend = 1'b1;
          end else if (scan_q.pend || c < CH_ZERO || c > CH_NINE) begin
            scan_d.lerr = 1'b1;
          end else if (!scan_q.lerr) begin
            nv = {1'b0, scan_q.val, 3'b000} + {3'b000, scan_q.val, 1'b0} +
                 {12'h000, 4'(c - CH_ZERO)};
            if (nv > {4'h0, max_body_q}) scan_d.lerr = 1'b1;
            else scan_d.val = nv[11:0];
          end
          // media type
          if (scan_q.tk < 6'(LEN_FORM)) begin
            scan_d.fm = scan_q.fm && to_lower(c) == lit_at(L_FORM, scan_q.tk);
          end else if (scan_q.tk == 6'(LEN_FORM)) begin
            scan_d.semi33 = (c == CH_SEMI);
            scan_d.ws33 = is_ws(c);
          end else if (!is_ws(c)) begin
            scan_d.nwa = 1'b1;
          end
          if (scan_q.tk < 6'(LEN_FORM + 1)) scan_d.tk = scan_q.tk + 6'd1;
        end
      end
    end

    if (ctl_q == CT_EVAL && out_free) begin
      emit = 1'b1;
      if (phase_q == PH_LINE) begin
        if (scan_q.sp != 2'd2 || !(scan_q.vm && scan_q.vk == 4'(LEN_VER)) ||
            scan_q.tgt_bad) begin
          fin = 1'b1;
          v = V_INVALID;
        end else begin
          post_d = scan_q.mpost && scan_q.mlen4;
          head_d = scan_q.mhead && scan_q.mlen4;
          if (!post_d && !head_d && !(scan_q.mget && scan_q.mlen3)) begin
            fin = 1'b1;
            v = V_METHOD;
          end else if (post_d && !(scan_q.st_m && scan_q.tl == 4'(LEN_SET))) begin
            fin = 1'b1;
            v = V_NOT_FOUND;
          end else begin
            phase_d = PH_HEAD;
          end
        end
      end else if (scan_len_q == '0) begin
        if (!post_q) begin
          fin = 1'b1;
          v = V_PAGE;
        end else if (!len_seen_q) begin
          fin = 1'b1;
          v = V_LEN_REQ;
        end else if (!type_valid_q) begin
          fin = 1'b1;
          v = V_MEDIA;
        end else if (decl_q == '0) begin
          fin = 1'b1;
          v = V_FORM;
        end else begin
          phase_d = PH_BODY;
        end
      end else if (!scan_q.col || scan_q.col0) begin
        fin = 1'b1;
        v = V_BAD_HDR;
      end else begin
        case (scan_q.hk)
          HK_LEN: begin
            if (len_seen_q) begin
              fin = 1'b1;
              v = V_DUP_LEN;
            end else if (!scan_q.vst) begin
              fin = 1'b1;
              v = V_EMPTY_LEN;
            end else if (scan_q.lerr) begin
              fin = 1'b1;
              v = V_TOO_LARGE;
            end else begin
              len_seen_d = 1'b1;
              decl_d = scan_q.val;
            end
          end
          HK_TYPE: begin
            if (type_seen_q) begin
              fin = 1'b1;
              v = V_DUP_TYPE;
            end else begin
              type_seen_d = 1'b1;
              type_valid_d = scan_q.fm && scan_q.tk >= 6'(LEN_FORM) &&
                             (scan_q.tk == 6'(LEN_FORM) || scan_q.semi33 ||
                              (scan_q.ws33 && !scan_q.nwa));
            end
          end
          HK_TE: begin
            fin = 1'b1;
            v = V_XFER_ENC;
          end
          default: fin = 1'b0;
        endcase
      end
      if (!fin) line_len_d = '0;
    end

    if (fin) phase_d = PH_DONE;

    res = '0;
    if (!ign) begin
      res.verdict = v;
      res.http_status = status_of(v);
      res.is_head = head_d;
      res.body_byte = bbyte;
      res.body_byte_valid = bval;
      res.body_length = body_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= CT_IDLE;
      phase_q <= PH_LINE;
      line_len_q <= '0;
      last_cr_q <= 1'b0;
      hdr_cnt_q <= '0;
      post_q <= 1'b0;
      head_q <= 1'b0;
      len_seen_q <= 1'b0;
      type_seen_q <= 1'b0;
      type_valid_q <= 1'b0;
      decl_q <= '0;
      body_cnt_q <= '0;
      max_hdr_q <= MAX_HDR_RST;
      max_body_q <= MAX_BODY_RST;
      scan_q <= '0;
      scan_len_q <= '0;
      idx_q <= '0;
      pos_q <= '0;
      rv_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
      phase_q <= phase_d;
      line_len_q <= line_len_d;
      last_cr_q <= last_cr_d;
      hdr_cnt_q <= hdr_cnt_d;
      post_q <= post_d;
      head_q <= head_d;
      len_seen_q <= len_seen_d;
      type_seen_q <= type_seen_d;
      type_valid_q <= type_valid_d;
      decl_q <= decl_d;
      body_cnt_q <= body_cnt_d;
      scan_q <= scan_d;
      scan_len_q <= scan_len_d;
      idx_q <= idx_d;
      pos_q <= pos_d;
      rv_q <= rv_d;
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_MAX_HDR:  max_hdr_q <= cfg_data_i;
          REG_MAX_BODY: max_body_q <= cfg_data_i;
          default:      max_hdr_q <= max_hdr_q;
        endcase
      end
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= res;
  end

  `HRHP_ASSERT_NOW(a_no_write_in_scan, ctl_q != CT_IDLE, !mem_we && !in_ready_o,
                   "line store written or input taken during line replay")
  `HRHP_ASSERT_NOW(a_body_verdict, out_valid_o && out_data_o.body_byte_valid,
                   out_data_o.verdict == V_PROGRESS || out_data_o.verdict == V_FORM,
                   "body byte with a verdict other than in progress or form ready")
  `HRHP_ASSERT_NEXT(a_done_ignores,
                    in_acc && !in_data_i.action && phase_q == PH_DONE,
                    out_valid_q && out_q.verdict == V_PROGRESS && phase_q == PH_DONE,
                    "byte after a final verdict was not ignored")

endmodule
